// ----- design/nat64as_pkg.sv -----
// shared types and constants for the nat64 address synthesis block
package nat64as_pkg;

  // prefix length codes as carried on the result stream
  typedef enum logic [2:0] {
    PrefixLen96   = 3'd0,
    PrefixLen64   = 3'd1,
    PrefixLen56   = 3'd2,
    PrefixLen48   = 3'd3,
    PrefixLen40   = 3'd4,
    PrefixLen32   = 3'd5,
    PrefixUnknown = 3'd6
  } prefix_e;

  // well-known ipv4 addresses expected inside the synthesized address
  localparam logic [31:0] KnownAddrA   = 32'hC000_00AA;  // 192.0.0.170
  localparam logic [31:0] KnownAddrB   = 32'hC000_00AB;  // 192.0.0.171
  localparam logic [31:0] KnownAddrDoc = 32'hC000_0201;  // 192.0.2.1

  // field widths
  localparam int unsigned AddrHalfW = 64;
  localparam int unsigned Ipv4W     = 32;
  localparam int unsigned InDataW   = 160;
  localparam int unsigned OutDataW  = 136;

  // one input request
  typedef struct packed {
    logic [Ipv4W-1:0]     ipv4_addr;
    logic [AddrHalfW-1:0] addr_low;
    logic [AddrHalfW-1:0] addr_high;
  } request_t;

  // one rewritten address with its status
  typedef struct packed {
    prefix_e              prefix_code;
    logic                 prefix_valid;
    logic [AddrHalfW-1:0] result_low;
    logic [AddrHalfW-1:0] result_high;
  } result_t;

endpackage

// ----- design/nat64as_rewrite.sv -----
// prefix detection, embedded address check and ipv4 rewrite
module nat64as_rewrite (
  input  nat64as_pkg::request_t req_i,
  input  logic                  expect_doc_i,
  output nat64as_pkg::result_t  result_o
);

  logic [7:0]           b     [16];
  logic [7:0]           r     [16];
  logic [7:0]           v4    [4];
  logic [15:7]          nz;
  logic [8:0]           tz;
  logic [31:0]          emb;
  logic                 force_u;
  logic                 match;
  logic [63:0]          hi;
  logic [63:0]          lo;
  nat64as_pkg::prefix_e code;

  // split the address and target into bytes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i]     = req_i.addr_high[63-8*i -: 8];
      b[8 + i] = req_i.addr_low[63-8*i -: 8];
    end
    for (int i = 0; i < 4; i++) begin
      v4[i] = req_i.ipv4_addr[31-8*i -: 8];
    end
    for (int i = 7; i < 16; i++) begin
      nz[i] = |b[i];
    end
  end

  // tz[k]: the last k bytes are all zero
  always_comb begin
    tz[0] = 1'b1;
    for (int k = 1; k < 9; k++) begin
      tz[k] = tz[k-1] & ~nz[16-k];
    end
  end

  // prefix length from the trailing zero byte count
  always_comb begin
    if (nz[15]) begin
      code = nat64as_pkg::PrefixLen96;
    end else if (tz[3] && nz[12]) begin
      code = nat64as_pkg::PrefixLen64;
    end else if (tz[4] && nz[11]) begin
      code = nat64as_pkg::PrefixLen56;
    end else if (tz[5] && nz[10]) begin
      code = nat64as_pkg::PrefixLen48;
    end else if (tz[6] && nz[9]) begin
      code = nat64as_pkg::PrefixLen40;
    end else if (tz[8] && nz[7]) begin
      code = nat64as_pkg::PrefixLen32;
    end else begin
      code = nat64as_pkg::PrefixUnknown;
    end
  end

  // pick the embedded address and drop the target into its place
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      r[i] = b[i];
    end
    force_u = 1'b1;
    case (code)
      nat64as_pkg::PrefixLen64: begin
        emb = {b[9], b[10], b[11], b[12]};
        r[9] = v4[0]; r[10] = v4[1]; r[11] = v4[2]; r[12] = v4[3];
      end
      nat64as_pkg::PrefixLen56: begin
        emb = {b[7], b[9], b[10], b[11]};
        r[7] = v4[0]; r[9] = v4[1]; r[10] = v4[2]; r[11] = v4[3];
      end
      nat64as_pkg::PrefixLen48: begin
        emb = {b[6], b[7], b[9], b[10]};
        r[6] = v4[0]; r[7] = v4[1]; r[9] = v4[2]; r[10] = v4[3];
      end
      nat64as_pkg::PrefixLen40: begin
        emb = {b[5], b[6], b[7], b[9]};
        r[5] = v4[0]; r[6] = v4[1]; r[7] = v4[2]; r[9] = v4[3];
      end
      nat64as_pkg::PrefixLen32: begin
        emb = {b[4], b[5], b[6], b[7]};
        r[4] = v4[0]; r[5] = v4[1]; r[6] = v4[2]; r[7] = v4[3];
      end
      default: begin
        // /96 and unrecognized counts both use the last four bytes
        emb = {b[12], b[13], b[14], b[15]};
        r[12] = v4[0]; r[13] = v4[1]; r[14] = v4[2]; r[15] = v4[3];
        force_u = 1'b0;
      end
    endcase
    // u byte is reserved and cleared for the /64 to /32 prefixes
    if (force_u) begin
      r[8] = 8'd0;
    end
  end

  // compare against the expected well-known address
  always_comb begin
    if (code == nat64as_pkg::PrefixUnknown) begin
      match = 1'b0;
    end else if (expect_doc_i) begin
      match = (emb == nat64as_pkg::KnownAddrDoc);
    end else begin
      match = (emb == nat64as_pkg::KnownAddrA) || (emb == nat64as_pkg::KnownAddrB);
    end
  end

  // reassemble the rewritten address
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hi[63-8*i -: 8] = r[i];
      lo[63-8*i -: 8] = r[8 + i];
    end
  end

  assign result_o.result_high  = hi;
  assign result_o.result_low   = lo;
  assign result_o.prefix_valid = match;
  assign result_o.prefix_code  = code;

endmodule

// ----- design/nat64_address_synthesis.sv -----
// top level of the nat64 address synthesis block
// Rewrites a DNS64-synthesized IPv6 address with a target IPv4 address at the
// RFC 6052 positions, inferring the prefix length (/96 to /32) from the count
// of trailing zero bytes and checking the embedded well-known IPv4 address
// (192.0.0.170/171, or 192.0.2.1 when cfg_data_i was written to 1). One
// request is taken every clock while the result side does not stall; each
// result passes through the input register and then the result register,
// with the combinational rewrite logic between them. Backpressure on the
// result side stalls both registers. cfg_data_i is to be written only while
// no request is in flight.
module nat64_address_synthesis (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,     // expect_doc_address
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,   // addr_high, addr_low, ipv4_addr
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // result_high, result_low, prefix_valid,
                                       // prefix_code, zero pad
);

  logic                  expect_doc_q;
  logic                  in_valid_q;
  nat64as_pkg::request_t in_req_q;
  logic                  out_valid_q;
  nat64as_pkg::result_t  out_res_q;
  nat64as_pkg::result_t  res_d;
  logic                  out_ready;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_doc_q <= 1'b0;
    end else if (cfg_valid_i) begin
      expect_doc_q <= cfg_data_i;
    end
  end

  // stall handling: each stage moves when the one after it has room
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q <= s_axis_tdata;
    end
  end

  // rewrite logic
  nat64as_rewrite u_rewrite (
    .req_i        (in_req_q),
    .expect_doc_i (expect_doc_q),
    .result_o     (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_res_q};

endmodule
